>>> src/rsp_packet_deframer_core_macros.svh
// Assertion macros for the serial debug packet deframer.
// Included by the top level; expects clk_i and rst_ni in the including scope.
`ifndef RSP_PACKET_DEFRAMER_CORE_MACROS_SVH
`define RSP_PACKET_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RSPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RSPD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define RSPD_ASSERT(lbl, prop, msg)
`define RSPD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> src/rspd_pkg.sv
// Shared types, character codes and helpers for the packet deframer.
// No dependencies; used by rspd_parser and rsp_packet_deframer_core.
package rspd_pkg;

  localparam int unsigned MaxPayload = 255;

  localparam logic [7:0] ChOpen  = 8'h24;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChNote  = 8'h25;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;

  localparam int unsigned TdataWidth = 56;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_HI   = 2'd2,
    PH_LO   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_VERDICT = 2'd1,
    KIND_ACK     = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] received_sum;
    logic [7:0] computed_sum;
    logic [7:0] ack_char;
    logic       checksum_ok;
    logic [7:0] packet_length;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    kind_e      kind;
  } result_t;

  // Hex letters of either case map to 10..15; anything else is its code minus '0'.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h30;
    end
    return v;
  endfunction

endpackage

>>> src/rspd_parser.sv
// Framing state machine and checksum datapath of the packet deframer.
// Depends on rspd_pkg; produces at most one result per accepted byte.
module rspd_parser #(
  parameter int unsigned MaxPayload = rspd_pkg::MaxPayload
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  output logic              res_vld_o,
  output rspd_pkg::result_t res_o
);

  rspd_pkg::phase_e phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] count_q, count_d;
  logic [7:0] high_q, high_d;
  logic       ovf_q, ovf_d;

  logic [7:0] hex;
  logic [7:0] got;
  logic       room;
  logic       ok;

  assign hex  = rspd_pkg::hex_value(rx_byte_i);
  assign got  = high_q | hex;
  assign room = count_q < 8'(MaxPayload);
  assign ok   = (got == sum_q) && !ovf_q;

  // Next state and datapath registers.
  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    count_d = count_q;
    high_d  = high_q;
    ovf_d   = ovf_q;
    if (accept_i) begin
      case (phase_q)
        rspd_pkg::PH_IDLE: begin
          if (rx_byte_i == rspd_pkg::ChOpen) begin
            phase_d = rspd_pkg::PH_BODY;
            sum_d   = '0;
            count_d = '0;
            high_d  = '0;
            ovf_d   = 1'b0;
          end
        end
        rspd_pkg::PH_BODY: begin
          if (rx_byte_i == rspd_pkg::ChHash) begin
            phase_d = rspd_pkg::PH_HI;
          end else begin
            sum_d = sum_q + rx_byte_i;
            if (room) begin
              count_d = count_q + 8'd1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        rspd_pkg::PH_HI: begin
          high_d  = {hex[3:0], 4'b0000};
          phase_d = rspd_pkg::PH_LO;
        end
        rspd_pkg::PH_LO: begin
          phase_d = rspd_pkg::PH_IDLE;
        end
        default: begin
          phase_d = rspd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Result for the byte at the input.
  always_comb begin
    res_vld_o = 1'b0;
    res_o     = '0;
    case (phase_q)
      rspd_pkg::PH_IDLE: begin
        if (rx_byte_i == rspd_pkg::ChNote) begin
          res_vld_o      = accept_i;
          res_o.kind     = rspd_pkg::KIND_ACK;
          res_o.ack_char = rspd_pkg::ChPlus;
        end
      end
      rspd_pkg::PH_BODY: begin
        if (rx_byte_i != rspd_pkg::ChHash && room) begin
          res_vld_o        = accept_i;
          res_o.kind       = rspd_pkg::KIND_PAYLOAD;
          res_o.data_byte  = rx_byte_i;
          res_o.byte_index = count_q;
        end
      end
      rspd_pkg::PH_LO: begin
        res_vld_o           = accept_i;
        res_o.kind          = rspd_pkg::KIND_VERDICT;
        res_o.packet_length = count_q;
        res_o.checksum_ok   = ok;
        res_o.ack_char      = ok ? rspd_pkg::ChPlus : rspd_pkg::ChMinus;
        res_o.computed_sum  = sum_q;
        res_o.received_sum  = got;
      end
      default: begin
        res_vld_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rspd_pkg::PH_IDLE;
      sum_q   <= '0;
      count_q <= '0;
      high_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      high_q  <= high_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

>>> src/rsp_packet_deframer_core.sv
// Packet deframer for a remote serial debug link: one received byte per beat in,
// payload, verdict and acknowledgement beats out. Depends on rspd_pkg,
// rspd_parser and the assertion macro header.
//
// The framing state and checksum are updated at the input handshake and the result
// lands in the output (or skid) register on the same edge, so a byte can be accepted on every
// cycle while no skid beat waits. A skid register behind the output register holds
// one more beat; s_axis_tready_o falls only while that skid beat is waiting, so a
// stalled output costs throughput only after two beats queue up.
// Payload beyond MaxPayload bytes (255 by default) is dropped and forces a '-'
// verdict.
`include "rsp_packet_deframer_core_macros.svh"

module rsp_packet_deframer_core #(
  parameter int unsigned MaxPayload = rspd_pkg::MaxPayload
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [7:0] rx_byte
  input  logic [7:0]                        s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [7:0] data_byte, [15:8] byte_index, [23:16] packet_length, [24] checksum_ok,
  // [32:25] ack_char, [40:33] computed_sum, [48:41] received_sum, [55:49] zero
  output logic [rspd_pkg::TdataWidth-1:0]   m_axis_tdata_o,
  // [1:0] kind
  output logic [1:0]                        m_axis_tuser_o
);

  logic              accept;
  logic              res_vld;
  rspd_pkg::result_t res;

  logic              out_vld_q, out_vld_d;
  rspd_pkg::result_t out_q, out_d;
  logic              skid_vld_q, skid_vld_d;
  rspd_pkg::result_t skid_q, skid_d;
  logic              out_free;
  logic              verdict_out;
  logic [7:0]        verdict_char;

  assign s_axis_tready_o = !skid_vld_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  rspd_parser #(
    .MaxPayload (MaxPayload)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (s_axis_tdata_i),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  assign out_free = !out_vld_q || m_axis_tready_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (out_free) begin
      if (skid_vld_q) begin
        // No new beat can arrive while the skid register is full.
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = res_vld;
        out_d     = res;
      end
    end else if (res_vld) begin
      skid_vld_d = 1'b1;
      skid_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {7'b0000000, out_q.received_sum, out_q.computed_sum,
                            out_q.ack_char, out_q.checksum_ok, out_q.packet_length,
                            out_q.byte_index, out_q.data_byte};

  assign verdict_out  = out_vld_q && out_q.kind == rspd_pkg::KIND_VERDICT;
  assign verdict_char = out_q.checksum_ok ? rspd_pkg::ChPlus : rspd_pkg::ChMinus;

  `RSPD_ASSERT(a_skid_behind_out, skid_vld_q |-> out_vld_q, "skid beat without output beat")
  `RSPD_ASSERT(a_stall_to_skid, !out_free && res_vld |=> skid_vld_q, "stalled result lost")
  `RSPD_ASSERT(a_verdict_ack, verdict_out |-> out_q.ack_char == verdict_char, "bad verdict char")

endmodule

>>> verif/rsp_packet_deframer_core_test.sv
// Self-checking testbench for rsp_packet_deframer_core: streams framed packets, notifications
// and line noise into the deframer and checks every output beat against a behavioral model.
// Depends on rspd_pkg and the deframer RTL only.
module rsp_packet_deframer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam int unsigned StallLimit = 2000;

  // Behavioral model of the framing state plus the queue of beats it predicts.
  class deframe_predictor;
    rspd_pkg::phase_e  frame_phase;
    logic [7:0]        payload_sum;
    logic [7:0]        kept_count;
    logic [7:0]        high_nibble;
    bit                dropped;
    rspd_pkg::result_t expected_beats[$];
    int unsigned       errors;
    int unsigned       payload_beats;
    int unsigned       verdicts_ok;
    int unsigned       verdicts_bad;
    int unsigned       overflow_packets;
    int unsigned       ack_beats;

    function new();
      frame_phase = rspd_pkg::PH_IDLE;
      payload_sum = '0;
      kept_count  = '0;
      high_nibble = '0;
      dropped     = 1'b0;
    endfunction

    // Hex letters of either case decode to 10..15; every other code is taken minus '0'.
    function logic [7:0] char_value(input logic [7:0] c);
      if (c >= CharUpperA && c < CharUpperA + 8'd6) return c - CharUpperA + 8'd10;
      if (c >= CharLowerA && c < CharLowerA + 8'd6) return c - CharLowerA + 8'd10;
      return c - CharZero;
    endfunction

    function void note_rx_byte(input logic [7:0] c);
      rspd_pkg::result_t beat;
      logic [7:0]        got;
      logic [7:0]        hv;
      bit                ok;
      beat = '0;
      case (frame_phase)
        rspd_pkg::PH_IDLE: begin
          if (c == rspd_pkg::ChOpen) begin
            frame_phase = rspd_pkg::PH_BODY;
            payload_sum = '0;
            kept_count  = '0;
            high_nibble = '0;
            dropped     = 1'b0;
          end else if (c == rspd_pkg::ChNote) begin
            beat.kind     = rspd_pkg::KIND_ACK;
            beat.ack_char = rspd_pkg::ChPlus;
            expected_beats.push_back(beat);
            ack_beats++;
          end
        end
        rspd_pkg::PH_BODY: begin
          if (c == rspd_pkg::ChHash) begin
            frame_phase = rspd_pkg::PH_HI;
          end else begin
            payload_sum = payload_sum + c;
            if (kept_count < rspd_pkg::MaxPayload) begin
              beat.kind       = rspd_pkg::KIND_PAYLOAD;
              beat.data_byte  = c;
              beat.byte_index = kept_count;
              kept_count      = kept_count + 8'd1;
              expected_beats.push_back(beat);
              payload_beats++;
            end else begin
              dropped = 1'b1;
            end
          end
        end
        rspd_pkg::PH_HI: begin
          hv          = char_value(c);
          high_nibble = {hv[3:0], 4'h0};
          frame_phase = rspd_pkg::PH_LO;
        end
        default: begin
          got = high_nibble | char_value(c);
          ok  = (got == payload_sum) && !dropped;
          beat.kind          = rspd_pkg::KIND_VERDICT;
          beat.packet_length = kept_count;
          beat.checksum_ok   = ok;
          beat.ack_char      = ok ? rspd_pkg::ChPlus : rspd_pkg::ChMinus;
          beat.computed_sum  = payload_sum;
          beat.received_sum  = got;
          expected_beats.push_back(beat);
          if (ok) verdicts_ok++;
          else verdicts_bad++;
          if (dropped) overflow_packets++;
          frame_phase = rspd_pkg::PH_IDLE;
        end
      endcase
    endfunction

    task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
      errors++;
      $display("[%0t] mismatch: %s got %h, expected %h", $realtime, what, got, want);
    endtask

    task compare_field(input string what, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report_mismatch(what, got, want);
    endtask

    task check_beat(input logic [1:0] kind, input logic [rspd_pkg::TdataWidth-1:0] data);
      rspd_pkg::result_t want;
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected output beat, kind", {6'd0, kind}, 8'hxx);
        return;
      end
      want = expected_beats.pop_front();
      compare_field("kind", {6'd0, kind}, {6'd0, want.kind});
      compare_field("data_byte", data[7:0], want.data_byte);
      compare_field("byte_index", data[15:8], want.byte_index);
      compare_field("packet_length", data[23:16], want.packet_length);
      compare_field("checksum_ok", {7'd0, data[24]}, {7'd0, want.checksum_ok});
      compare_field("ack_char", data[32:25], want.ack_char);
      compare_field("computed_sum", data[40:33], want.computed_sum);
      compare_field("received_sum", data[48:41], want.received_sum);
      compare_field("tdata padding", {1'b0, data[55:49]}, 8'd0);
    endtask

    task flush_leftovers();
      while (expected_beats.size() != 0) begin
        report_mismatch("missing output beat, kind", {6'd0, expected_beats[0].kind}, 8'hxx);
        void'(expected_beats.pop_front());
      end
    endtask
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [7:0]                      s_axis_tdata_i = 8'd0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [rspd_pkg::TdataWidth-1:0] m_axis_tdata_o;
  logic [1:0]                      m_axis_tuser_o;

  deframe_predictor model = new();
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_idle_pct = 0;
  int unsigned      rx_hold_cycles = 0;
  int unsigned      bytes_sent = 0;
  int unsigned      stall_cycles = 0;

  rsp_packet_deframer_core dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  always begin
    #1ns clk_i = 1'b1;
    #1ns clk_i = 1'b0;
  end

  // Receiver: random back-pressure, or a solid hold-off while a hold is pending.
  always @(posedge clk_i) begin
    if (rx_hold_cycles != 0) begin
      m_axis_tready_i <= 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o === 1'b1 && m_axis_tready_i) begin
      model.check_beat(m_axis_tuser_o, m_axis_tdata_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Timeout: no beat moved for %0d cycles", StallLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Called right after a rising edge; returns on the edge that accepts the byte.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    model.note_rx_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return CharZero + {4'd0, nib};
    return ($urandom_range(0, 1) ? CharUpperA : CharLowerA) + {4'd0, nib} - 8'd10;
  endfunction

  // Mostly framing characters, so noise keeps opening, closing and acknowledging.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0: return rspd_pkg::ChOpen;
      1: return rspd_pkg::ChHash;
      2: return rspd_pkg::ChNote;
      3: return $urandom_range(0, 1) ? rspd_pkg::ChPlus : rspd_pkg::ChMinus;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_packet(input int unsigned len, input bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] check;
    sum = '0;
    send_byte(rspd_pkg::ChOpen);
    repeat (len) begin
      do b = 8'($urandom_range(0, 255)); while (b == rspd_pkg::ChHash);
      sum = sum + b;
      send_byte(b);
    end
    send_byte(rspd_pkg::ChHash);
    if (good_sum || $urandom_range(0, 1)) begin
      check = good_sum ? sum : 8'($urandom_range(0, 255));
      send_byte(hex_char(check[7:4]));
      send_byte(hex_char(check[3:0]));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int unsigned quota, input int unsigned long_len);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    start = bytes_sent;
    if (long_len != 0) send_packet(long_len, 1'b1);
    while (bytes_sent - start < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        send_packet(len, $urandom_range(0, 3) != 0);
      end else if (pick < 80) begin
        send_byte(rspd_pkg::ChNote);
      end else if (pick < 90) begin
        send_byte(noise_byte());
      end else begin
        // Packet cut short: whatever follows is taken as its payload.
        send_byte(rspd_pkg::ChOpen);
        repeat ($urandom_range(0, 4)) send_byte(noise_byte());
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (model.expected_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    logic [7:0] seq[$];
    seq = '{8'h00, 8'hFF, rspd_pkg::ChPlus, rspd_pkg::ChMinus, rspd_pkg::ChHash,
            rspd_pkg::ChNote, rspd_pkg::ChOpen, rspd_pkg::ChNote, rspd_pkg::ChOpen,
            8'h00, 8'hFF, rspd_pkg::ChHash, "4", "8",
            rspd_pkg::ChOpen, 8'hAB, rspd_pkg::ChHash, "A", "b",
            rspd_pkg::ChOpen, rspd_pkg::ChHash, 8'hFF, "0"};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 9;
    rx_idle_pct = 48;
    run_directed();
    // Exactly the largest payload that is still kept whole.
    run_random(360, rspd_pkg::MaxPayload);
    drain();

    tx_idle_pct = 48;
    rx_idle_pct = 9;
    // Too long: bytes past the limit are dropped and the verdict must be a reject.
    run_random(360, $urandom_range(rspd_pkg::MaxPayload + 1, 300));
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // Hold the output long enough for the skid buffer to fill and stall the input.
    rx_hold_cycles = 60;
    send_packet(30, 1'b1);
    run_random(330, 0);
    drain();

    repeat (10) @(posedge clk_i);
    model.flush_leftovers();
    $display("Sent %0d bytes: %0d payload beats, %0d notification acks, %0d verdicts",
             bytes_sent, model.payload_beats, model.ack_beats,
             model.verdicts_ok + model.verdicts_bad);
    $display("Verdicts: %0d accepted, %0d rejected, %0d overlong; %0d mismatches",
             model.verdicts_ok, model.verdicts_bad, model.overflow_packets, model.errors);
    if (model.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
